// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define HSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define HSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hsv2rgb_pkg.sv =====
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, constants, sector codes and helpers for the HSV to RGB converter.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int FRAC_BITS_DEF = 12;   // hue fraction bits within a sector

  localparam int HUE_W      = 16;      // degrees * 16, signed
  localparam int SV_W       = 14;      // signed Q1.12
  localparam int UNIT_W     = 13;      // unsigned Q1.12, 0..4096
  localparam int UNIT_SHIFT = 12;
  localparam logic [UNIT_W-1:0] UNIT = UNIT_W'(4096);

  // hue + six full turns is always positive and below 2^17
  localparam int XW = HUE_W + 1;
  localparam logic [XW-1:0] HUE_OFFSET = XW'(34560);

  // sector index = x / 960 via reciprocal, result off by at most one
  localparam int QW                       = 7;
  localparam int DIV960_MUL_W             = 18;
  localparam logic [DIV960_MUL_W-1:0] DIV960_MUL = DIV960_MUL_W'(139810);
  localparam int DIV960_SHIFT             = 27;
  localparam int SPAN_W                   = 10;
  localparam logic [SPAN_W-1:0] SECTOR_SPAN = SPAN_W'(960);

  // 960 = 15 * 64
  localparam int SPAN_POW2_SHIFT = 6;
  localparam int ODD_W           = 4;
  localparam logic [ODD_W-1:0] SPAN_ODD = ODD_W'(15);

  // floor(n / 6) = (n * 43) >> 8, exact for n < 128
  localparam int DIV6_W     = 13;
  localparam int DIV6_MUL   = 43;
  localparam int DIV6_SHIFT = 8;
  localparam int NUM_SECTORS = 6;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  // clamp signed Q1.12 to 0..1.0
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [SV_W-1:0] a);
    logic [UNIT_W-1:0] res;
    if (a[SV_W-1]) begin
      res = '0;
    end else if (a[SV_W-2:0] > UNIT) begin
      res = UNIT;
    end else begin
      res = a[SV_W-2:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined HSV to RGB colour conversion, one pixel per clock unless the output stalls.
// ---------------------------------------------------------------------------
// Takes one HSV request per clock while the output side keeps up: a
// nine-stage pipeline, with a valid bit carried alongside each stage and a
// per-stage ready chain, so a stall at the output only holds the stages that
// are full and bubbles still close up. One colour per cycle leaves while the
// output is not stalled. Hue (degrees, 4 fraction bits, any signed value) is
// wrapped into 0..360 and split into a 60 degree sector and a FRAC_BITS
// fraction; saturation and value are clamped to 0..1.0. Zero saturation
// gives grey. Outputs are unsigned Q1.12, 4096 = full scale, all products
// truncated once. No state is kept between colours.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [hsv2rgb_pkg::HUE_W-1:0]  hue,
  input  logic signed [hsv2rgb_pkg::SV_W-1:0]   saturation,
  input  logic signed [hsv2rgb_pkg::SV_W-1:0]   brightness,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [hsv2rgb_pkg::UNIT_W-1:0] red,
  output logic        [hsv2rgb_pkg::UNIT_W-1:0] green,
  output logic        [hsv2rgb_pkg::UNIT_W-1:0] blue
);
  import hsv2rgb_pkg::*;

  localparam int NSTG  = 9;
  localparam int YW    = FRAC_BITS + 4;          // rem << (FRAC_BITS-6), < 15 * 2^FRAC_BITS
  localparam int K15   = FRAC_BITS + 8;          // reciprocal shift for / 15
  localparam int MW15  = FRAC_BITS + 5;
  localparam int PW    = FRAC_BITS + UNIT_W;     // s*f and 1 - s*f terms
  localparam int QPW   = PW + UNIT_W;            // v * term
  localparam int P15W  = YW + MW15;
  localparam int X960W = XW + DIV960_MUL_W;
  localparam int QDW   = QW - 3;                 // sector index / 6 <= 11

  localparam logic [MW15-1:0]    DIV15_MUL = MW15'((64'd1 << K15) / 64'd15);
  localparam logic [PW-1:0]      ONE_F     = PW'(64'd1 << (UNIT_SHIFT + FRAC_BITS));
  localparam logic [FRAC_BITS:0] FONE      = (FRAC_BITS + 1)'(64'd1 << FRAC_BITS);

  // ---------------- handshake: valid per stage, ready chain --------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;   // stage may load this cycle

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];

  // ---------------- stage 0: clamp s, v; offset hue ----------------------
  logic [UNIT_W-1:0] sat0, val0;
  logic [XW-1:0]     x0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sat0 <= clamp_unit(saturation);
      val0 <= clamp_unit(brightness);
      x0   <= {hue[HUE_W-1], hue} + HUE_OFFSET;
    end
  end

  // ---------------- stage 1: sector index estimate, p --------------------
  logic [X960W-1:0]    prod960;
  logic [2*UNIT_W-1:0] pprod;
  logic [UNIT_W-1:0]   sat1, val1, p1;
  logic [XW-1:0]       x1;
  logic [QW-1:0]       qe1;

  assign prod960 = X960W'(x0) * X960W'(DIV960_MUL);
  assign pprod   = (2*UNIT_W)'(val0) * (2*UNIT_W)'(UNIT - sat0);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sat1 <= sat0;
      val1 <= val0;
      x1   <= x0;
      qe1  <= prod960[DIV960_SHIFT +: QW];
      p1   <= pprod[UNIT_SHIFT +: UNIT_W];
    end
  end

  // ---------------- stage 2: correct index, remainder in sector ----------
  logic [XW-1:0]     r960;
  logic              wrap960;
  logic [XW-1:0]     rem_full;
  logic [UNIT_W-1:0] sat2, val2, p2;
  logic [QW-1:0]     qs2;
  logic [YW-1:0]     y2;

  assign r960     = x1 - XW'(qe1) * XW'(SECTOR_SPAN);
  assign wrap960  = (r960 >= XW'(SECTOR_SPAN));
  assign rem_full = wrap960 ? r960 - XW'(SECTOR_SPAN) : r960;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sat2 <= sat1;
      val2 <= val1;
      p2   <= p1;
      qs2  <= qe1 + QW'(wrap960);
      y2   <= YW'(rem_full[SPAN_W-1:0]) << (FRAC_BITS - SPAN_POW2_SHIFT);
    end
  end

  // ---------------- stage 3: sector = index mod 6, fraction estimate -----
  logic [DIV6_W-1:0] mul6;
  logic [QDW-1:0]    qd6;
  logic [QW-1:0]     sec_full;
  logic [P15W-1:0]   prod15;
  logic [UNIT_W-1:0] sat3, val3, p3;
  sector_t           sec3;
  logic [FRAC_BITS-1:0] fe3;
  logic [YW-1:0]     y3;

  assign mul6     = DIV6_W'(qs2) * DIV6_W'(DIV6_MUL);
  assign qd6      = mul6[DIV6_SHIFT +: QDW];
  assign sec_full = qs2 - QW'(qd6) * QW'(NUM_SECTORS);
  assign prod15   = P15W'(y2) * P15W'(DIV15_MUL);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sat3 <= sat2;
      val3 <= val2;
      p3   <= p2;
      sec3 <= sector_t'(sec_full[2:0]);
      fe3  <= prod15[K15 +: FRAC_BITS];
      y3   <= y2;
    end
  end

  // ---------------- stage 4: correct fraction ----------------------------
  logic [YW-1:0]        r15;
  logic [UNIT_W-1:0]    sat4, val4, p4;
  sector_t              sec4;
  logic [FRAC_BITS-1:0] f4;

  assign r15 = y3 - YW'(fe3) * YW'(SPAN_ODD);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sat4 <= sat3;
      val4 <= val3;
      p4   <= p3;
      sec4 <= sec3;
      f4   <= fe3 + FRAC_BITS'(r15 >= YW'(SPAN_ODD));
    end
  end

  // ---------------- stage 5: s*f and s*(1-f) -----------------------------
  logic [FRAC_BITS:0] onef;
  logic [UNIT_W-1:0]  val5, p5;
  sector_t            sec5;
  logic [PW-1:0]      sf5, sg5;
  logic               grey5;

  assign onef = FONE - (FRAC_BITS + 1)'(f4);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      val5  <= val4;
      p5    <= p4;
      sec5  <= sec4;
      sf5   <= PW'(sat4) * PW'(f4);
      sg5   <= PW'(PW'(sat4) * PW'(onef));
      grey5 <= (sat4 == '0);
    end
  end

  // ---------------- stage 6: 1 - s*f, 1 - s*(1-f) ------------------------
  logic [UNIT_W-1:0] val6, p6;
  sector_t           sec6;
  logic [PW-1:0]     aq6, at6;
  logic              grey6;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      val6  <= val5;
      p6    <= p5;
      sec6  <= sec5;
      aq6   <= ONE_F - sf5;
      at6   <= ONE_F - sg5;
      grey6 <= grey5;
    end
  end

  // ---------------- stage 7: q, t ----------------------------------------
  logic [QPW-1:0]    qprod, tprod;
  logic [UNIT_W-1:0] val7, p7, q7, t7;
  sector_t           sec7;
  logic              grey7;

  assign qprod = QPW'(val6) * QPW'(aq6);
  assign tprod = QPW'(val6) * QPW'(at6);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      val7  <= val6;
      p7    <= p6;
      sec7  <= sec6;
      q7    <= qprod[UNIT_SHIFT + FRAC_BITS +: UNIT_W];
      t7    <= tprod[UNIT_SHIFT + FRAC_BITS +: UNIT_W];
      grey7 <= grey6;
    end
  end

  // ---------------- stage 8: six-way select, output register -------------
  logic [UNIT_W-1:0] red_next, green_next, blue_next;

  always_comb begin
    case (sec7)
      SEC_RED_YEL: begin red_next = val7; green_next = t7;   blue_next = p7;   end
      SEC_YEL_GRN: begin red_next = q7;   green_next = val7; blue_next = p7;   end
      SEC_GRN_CYN: begin red_next = p7;   green_next = val7; blue_next = t7;   end
      SEC_CYN_BLU: begin red_next = p7;   green_next = q7;   blue_next = val7; end
      SEC_BLU_MAG: begin red_next = t7;   green_next = p7;   blue_next = val7; end
      default:     begin red_next = val7; green_next = p7;   blue_next = q7;   end
    endcase
    if (grey7) begin
      red_next   = val7;
      green_next = val7;
      blue_next  = val7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

// ===== rtl/hsv2rgb_checker.sv =====
// ---------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level assertions for the HSV to RGB converter, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv2rgb_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic        [hsv2rgb_pkg::UNIT_W-1:0] red,
  input logic        [hsv2rgb_pkg::UNIT_W-1:0] green,
  input logic        [hsv2rgb_pkg::UNIT_W-1:0] blue
);
  import hsv2rgb_pkg::*;

  logic [3*UNIT_W-1:0] rgb;
  logic                out_stall;
  logic                in_scale;

  assign rgb       = {red, green, blue};
  assign out_stall = out_valid && !out_ready;
  assign in_scale  = (red <= UNIT) && (green <= UNIT) && (blue <= UNIT);

  // held output request keeps its colour
  `HSV_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(rgb), "stalled output changed")

  // intensities never exceed full scale
  `HSV_ASSERT(a_out_range, out_valid |-> in_scale, "output above full scale")

  // input backs off only when every stage is full and the output is stalled
  `HSV_ASSERT(a_in_backpressure, !in_ready |-> out_stall, "input stalled with room left")

  // reset empties the pipeline
  `HSV_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid && in_ready, "not empty after reset")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HSV to RGB colour converter.
// ---------------------------------------------------------------------------
// Every accepted HSV request is run through a local fixed-point predictor.
// Each returned RGB request is checked field by field against the oldest
// prediction. A short directed set covers the corners; random colours then
// follow under four idling regimes on the input and output channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hsv2rgb_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int TURN      = 5760;     // 360 degrees, 4 fraction bits
  localparam int SPAN      = 960;      // 60 degrees
  localparam int QUIET_MAX = 4000;     // cycles with no transfer before giving up
  localparam int TAIL      = 24;       // drain margin, pipeline is nine deep
  localparam int PER_PHASE = 212;

  typedef struct packed {
    logic [UNIT_W-1:0] red;
    logic [UNIT_W-1:0] green;
    logic [UNIT_W-1:0] blue;
  } rgb_t;

  // Clamp signed Q1.12 into 0..1.0
  function automatic longint unsigned clip_unit(input logic signed [SV_W-1:0] x);
    if (x < 0) begin
      return 0;
    end
    if (int'(x) > 4096) begin
      return 4096;
    end
    return longint'(x);
  endfunction

  // Expected RGB for one HSV request, exact products truncated once
  function automatic rgb_t predict_rgb(input logic signed [HUE_W-1:0] h,
                                       input logic signed [SV_W-1:0]  s_in,
                                       input logic signed [SV_W-1:0]  v_in);
    longint unsigned s, v, f, rem, p, q, t, one_f, fone;
    int              wrapped;
    sector_t         sec;
    rgb_t            res;
    s = clip_unit(s_in);
    v = clip_unit(v_in);
    if (s == 0) begin
      // grey
      res.red   = v[UNIT_W-1:0];
      res.green = v[UNIT_W-1:0];
      res.blue  = v[UNIT_W-1:0];
      return res;
    end
    wrapped = (int'(h) + TURN * 6) % TURN;
    sec     = sector_t'(3'(wrapped / SPAN));
    rem     = longint'(wrapped % SPAN);
    fone    = 64'd1 << FRAC;
    f       = (rem << FRAC) / SPAN;
    one_f   = 64'd4096 << FRAC;
    p       = (v * (64'd4096 - s)) >> UNIT_SHIFT;
    q       = (v * (one_f - s * f)) >> (UNIT_SHIFT + FRAC);
    t       = (v * (one_f - s * (fone - f))) >> (UNIT_SHIFT + FRAC);
    case (sec)
      SEC_RED_YEL: res = '{v[12:0], t[12:0], p[12:0]};
      SEC_YEL_GRN: res = '{q[12:0], v[12:0], p[12:0]};
      SEC_GRN_CYN: res = '{p[12:0], v[12:0], t[12:0]};
      SEC_CYN_BLU: res = '{p[12:0], q[12:0], v[12:0]};
      SEC_BLU_MAG: res = '{t[12:0], p[12:0], v[12:0]};
      default:     res = '{v[12:0], p[12:0], q[12:0]};
    endcase
    return res;
  endfunction

  // Holds predicted colours in request order and checks returns against them
  class rgb_scoreboard;
    rgb_t rgb_due[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    task report(input string what, input int got, input int want);
      errors++;
      if (errors <= 60) begin
        $display("%0t MISMATCH %s got %0d want %0d", $realtime, what, got, want);
      end
    endtask

    function void note_request(input logic signed [HUE_W-1:0] h,
                               input logic signed [SV_W-1:0]  s,
                               input logic signed [SV_W-1:0]  v);
      rgb_due.push_back(predict_rgb(h, s, v));
    endfunction

    task check_request(input rgb_t got);
      rgb_t want;
      if (rgb_due.size() == 0) begin
        report("unexpected colour, red", int'(got.red), -1);
        return;
      end
      want = rgb_due.pop_front();
      if (got.red !== want.red)     report("red", int'(got.red), int'(want.red));
      if (got.green !== want.green) report("green", int'(got.green), int'(want.green));
      if (got.blue !== want.blue)   report("blue", int'(got.blue), int'(want.blue));
    endtask

    function int outstanding();
      return rgb_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [HUE_W-1:0]  hue = '0;
  logic signed [SV_W-1:0]   saturation = '0;
  logic signed [SV_W-1:0]   brightness = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [UNIT_W-1:0]        red;
  logic [UNIT_W-1:0]        green;
  logic [UNIT_W-1:0]        blue;

  int            idle_pct  = 0;   // chance per cycle that the sender holds off
  int            stall_pct = 0;   // chance per cycle that the receiver stalls
  int            quiet_cycles = 0;
  rgb_scoreboard sb = new();

  hsv_to_rgb_converter #(.FRAC_BITS(FRAC)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: ready decided once per falling edge
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // Both monitors sample pre-edge values at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_request(hue, saturation, brightness);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_request('{red, green, blue});
    end
  end

  // Watchdog: no transfer on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("hsv_to_rgb_converter verification failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid is held with a stable payload until the request is taken.
  task automatic send_hsv(input logic signed [HUE_W-1:0] h,
                          input logic signed [SV_W-1:0]  s,
                          input logic signed [SV_W-1:0]  v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly in range, with zeros, full scale and raw 14-bit noise mixed in
  function automatic logic signed [SV_W-1:0] pick_level();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return SV_W'($urandom_range(1, 4096));
    if (sel < 15) return '0;
    if (sel < 16) return SV_W'(4096);
    return SV_W'($urandom);
  endfunction

  function automatic logic signed [HUE_W-1:0] pick_hue();
    if ($urandom_range(0, 9) < 6) return HUE_W'($urandom_range(0, TURN - 1));
    return HUE_W'($urandom);
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Corners: every sector start, wrap points, clamping and grey
    send_hsv(0, 4096, 4096);
    send_hsv(960, 4096, 4096);
    send_hsv(1920, 4096, 4096);
    send_hsv(2880, 4096, 4096);
    send_hsv(3840, 4096, 4096);
    send_hsv(4800, 4096, 4096);
    send_hsv(5759, 4096, 4096);
    send_hsv(959, 4096, 4096);
    send_hsv(5760, 2048, 3000);       // exactly 360 degrees
    send_hsv(-1, 4096, 4096);         // just below zero
    send_hsv(-5760, 3000, 4000);
    send_hsv(-32768, 8191, 8191);     // most negative hue, both clamp high
    send_hsv(32767, -8192, -8192);    // most positive hue, both clamp low
    send_hsv(-32767, 5000, 3333);
    send_hsv(1234, 0, 2500);          // grey
    send_hsv(700, -1, 4095);          // negative saturation is grey too
    send_hsv(500, 4097, 4097);        // one above full scale
    send_hsv(2000, 1, 1);
    send_hsv(3000, 4095, 8191);
    send_hsv(480, 2048, 2048);
    send_hsv(4321, 8191, -1);
    send_hsv(16383, 2731, 4096);

    // Random colours: free flowing, sparse sender, heavy stalls, then both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 71; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        send_hsv(pick_hue(), pick_level(), pick_level());
      end
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (sb.errors == 0) begin
      $display("hsv_to_rgb_converter verification clean");
    end else begin
      $display("hsv_to_rgb_converter verification failed");
    end
    $finish;
  end

endmodule
